// ----- rtl/text_mode_terminal_writer_assert.svh -----
// Assertion macros for the text-mode terminal writer checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define TMTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmtw assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define TMTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmtw assertion failed");

`endif

// ----- rtl/tmtw_pkg.sv -----
// Shared constants, codes and structs of the text-mode terminal writer.
// No dependencies; used by every module of the block but tmtw_ram.
`timescale 1ns / 1ps
`default_nettype none

package tmtw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CellCount = COLUMNS * ROWS;
  localparam int IdxW      = $clog2(CellCount);
  localparam int RowW      = $clog2(ROWS + 1);
  localparam int ColW      = $clog2(COLUMNS);
  localparam int CntW      = $clog2((ROWS + 1) * COLUMNS);
  localparam int CellW     = 16;

  localparam int ModeW     = 2;
  localparam int CharW     = 8;
  localparam int CursorW   = 11;
  localparam int ColorW    = 8;
  localparam int RegRowW   = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;

  localparam logic [CharW-1:0] ChNul     = 8'd0;
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChSpace   = 8'd32;

  typedef enum logic [ModeW-1:0] {
    ModePrint     = 2'd0,
    ModeBackspace = 2'd1,
    ModeClear     = 2'd2,
    ModeRead      = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTextColor = 2'd0,
    CfgTopRow    = 2'd1,
    CfgEndRow    = 2'd2
  } cfg_reg_e;

  // Request to the block-move / fill engine.
  typedef struct packed {
    logic            go;
    logic            is_clear;
    logic [RowW-1:0] top;
    logic [RowW-1:0] fin;
  } sweep_cmd_t;

  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  addr;
    logic [CellW-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ----- rtl/tmtw_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tmtw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/tmtw_sweep.sv -----
// Scroll and region-clear engine: walks the cell store one cell a cycle.
// Depends on tmtw_pkg; reads and writes the store through the top level's RAM.
`timescale 1ns / 1ps
`default_nettype none

module tmtw_sweep (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tmtw_pkg::sweep_cmd_t          cmd_i,
  input  wire logic [tmtw_pkg::CellW-1:0]    blank_i,
  input  wire logic [tmtw_pkg::CellW-1:0]    rd_data_i,
  output logic      [tmtw_pkg::IdxW-1:0]     rd_addr_o,
  output tmtw_pkg::mem_wr_t                  wr_o,
  output logic                               done_o
);

  typedef enum logic [1:0] {SwIdle, SwRun, SwDrain} sw_state_e;

  localparam logic [tmtw_pkg::CntW-1:0] Cols  = tmtw_pkg::CntW'(tmtw_pkg::COLUMNS);
  localparam logic [tmtw_pkg::CntW-1:0] Cells = tmtw_pkg::CntW'(tmtw_pkg::CellCount);
  localparam logic [tmtw_pkg::CntW-1:0] ScrollStop =
    tmtw_pkg::CntW'((tmtw_pkg::ROWS + 1) * tmtw_pkg::COLUMNS);

  sw_state_e                   state_q;
  logic [tmtw_pkg::CntW-1:0]   cnt_q, stop_q;
  logic                        clear_q;
  logic                        pend_q, pend_blank_q;
  logic [tmtw_pkg::IdxW-1:0]   pend_addr_q;
  logic [tmtw_pkg::CntW-1:0]   start_s, stop_s;

  // Scroll reads one row ahead of where it writes; past the store end the
  // source is a blank, which fills the last row in the same pass.
  always_comb begin
    if (cmd_i.is_clear) begin
      start_s = tmtw_pkg::CntW'(cmd_i.top) * Cols;
      stop_s  = tmtw_pkg::CntW'(cmd_i.fin) * Cols;
    end else begin
      start_s = (tmtw_pkg::CntW'(cmd_i.top) + tmtw_pkg::CntW'(1)) * Cols;
      stop_s  = ScrollStop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SwIdle;
      cnt_q        <= '0;
      stop_q       <= '0;
      clear_q      <= 1'b0;
      pend_q       <= 1'b0;
      pend_blank_q <= 1'b0;
      pend_addr_q  <= '0;
    end else begin
      case (state_q)
        SwIdle: begin
          pend_q <= 1'b0;
          if (cmd_i.go) begin
            cnt_q   <= start_s;
            stop_q  <= stop_s;
            clear_q <= cmd_i.is_clear;
            state_q <= (start_s < stop_s) ? SwRun : SwDrain;
          end
        end
        SwRun: begin
          pend_q       <= 1'b1;
          pend_addr_q  <= clear_q ? tmtw_pkg::IdxW'(cnt_q) : tmtw_pkg::IdxW'(cnt_q - Cols);
          pend_blank_q <= clear_q || (cnt_q >= Cells);
          cnt_q        <= cnt_q + tmtw_pkg::CntW'(1);
          if (cnt_q == stop_q - tmtw_pkg::CntW'(1)) begin
            state_q <= SwDrain;
          end
        end
        SwDrain: begin
          pend_q  <= 1'b0;
          state_q <= SwIdle;
        end
        default: begin
          pend_q  <= 1'b0;
          state_q <= SwIdle;
        end
      endcase
    end
  end

  assign rd_addr_o = (cnt_q < Cells) ? tmtw_pkg::IdxW'(cnt_q) : '0;
  assign wr_o.en   = pend_q;
  assign wr_o.addr = pend_addr_q;
  assign wr_o.data = pend_blank_q ? blank_i : rd_data_i;
  assign done_o    = (state_q == SwDrain);

endmodule

`default_nettype wire

// ----- rtl/text_mode_terminal_writer.sv -----
// Top level of the text-mode terminal writer: cursor, command decode, output.
// Depends on tmtw_pkg, tmtw_ram (cell store) and tmtw_sweep (scroll/clear).
//
// Usage:
//  - s_axis carries one command per transaction: tuser = mode (print,
//    backspace, clear, read), tdata = char_code and cell_index.
//  - m_axis returns exactly one result per command: cursor cell after the
//    command plus the cell read (zero for modes other than read).
//  - cfg_* writes text_color, top_row or end_row; always ready. Writing a
//    region register homes the cursor. Write only while the block is idle.
//  - Print, newline and backspace that do not scroll give their result in the
//    cycle after acceptance and take the next command as it leaves; read goes
//    through the registered RAM read port in StRead and takes no command there.
//  - Scroll (print past the screen end) walks the store one cell a cycle from
//    top_row + 1 to the end, then a blank last row; clear walks top_row to end_row
//    the same way, or goes straight to its drain state if the region is empty.
//    Both are bounded by the single write port of the cell store.
//  - Reset homes the cursor to cell 0 and sets the registers to their reset
//    values; the store is left as is, so software clears it first.
//  - While a result waits on a stalled m_axis the block takes no new command.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_terminal_writer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [23:0]                       s_axis_tdata_i,   // char_code, cell_index
  input  wire logic [tmtw_pkg::ModeW-1:0]        s_axis_tuser_i,   // mode
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [31:0]                       m_axis_tdata_o,   // cursor_cell, cell_char,
                                                                   // cell_color
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tmtw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [tmtw_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {StIdle, StRead, StSweep} state_e;

  localparam logic [tmtw_pkg::RowW-1:0] LastRow  = tmtw_pkg::RowW'(tmtw_pkg::ROWS - 1);
  localparam logic [tmtw_pkg::RowW-1:0] RowsEnd  = tmtw_pkg::RowW'(tmtw_pkg::ROWS);
  localparam logic [tmtw_pkg::ColW-1:0] LastCol  = tmtw_pkg::ColW'(tmtw_pkg::COLUMNS - 1);
  localparam logic [tmtw_pkg::CntW-1:0] Cols     = tmtw_pkg::CntW'(tmtw_pkg::COLUMNS);

  state_e                            state_q, state_d;
  logic [tmtw_pkg::RowW-1:0]         row_q, row_d;
  logic [tmtw_pkg::ColW-1:0]         col_q, col_d;
  logic [tmtw_pkg::ColorW-1:0]       color_q, color_d;
  logic [tmtw_pkg::RegRowW-1:0]      top_q, top_d, end_q, end_d;
  logic                              rd_inrange_q, rd_inrange_d;
  logic                              out_valid_q, out_valid_d;
  logic [tmtw_pkg::CursorW-1:0]      out_cursor_q, out_cursor_d;
  logic [tmtw_pkg::CharW-1:0]        out_char_q, out_char_d;
  logic [tmtw_pkg::ColorW-1:0]       out_color_q, out_color_d;

  logic                              in_acc, emit;
  tmtw_pkg::mode_e                   mode;
  logic [tmtw_pkg::CharW-1:0]        ch;
  logic [tmtw_pkg::CursorW-1:0]      idx;
  logic [tmtw_pkg::RowW-1:0]         top_lim, end_lim, cfg_top_lim, row_n;
  logic [tmtw_pkg::CntW-1:0]         cur_idx;
  logic [tmtw_pkg::CellW-1:0]        blank, rd_data;
  logic [tmtw_pkg::IdxW-1:0]         idle_rd_addr, sw_rd_addr, rd_addr;
  tmtw_pkg::mem_wr_t                 idle_wr, sw_wr, mem_wr;
  tmtw_pkg::sweep_cmd_t              sw_cmd;
  logic                              sw_done;

  assign mode = tmtw_pkg::mode_e'(s_axis_tuser_i);
  assign ch   = s_axis_tdata_i[7:0];
  assign idx  = s_axis_tdata_i[18:8];

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle) && (!out_valid_q || m_axis_tready_i);
  assign cfg_ready_o     = 1'b1;

  // Region registers are clamped to the screen wherever they are used.
  assign top_lim = (32'(top_q) > tmtw_pkg::ROWS - 1) ? LastRow : tmtw_pkg::RowW'(top_q);
  assign end_lim = (32'(end_q) > tmtw_pkg::ROWS) ? RowsEnd : tmtw_pkg::RowW'(end_q);
  assign cfg_top_lim = (32'(cfg_data_i[tmtw_pkg::RegRowW-1:0]) > tmtw_pkg::ROWS - 1) ?
                       LastRow : tmtw_pkg::RowW'(cfg_data_i[tmtw_pkg::RegRowW-1:0]);

  assign cur_idx = tmtw_pkg::CntW'(row_q) * Cols + tmtw_pkg::CntW'(col_q);
  assign blank   = {color_q, tmtw_pkg::ChSpace};

  assign idle_rd_addr = (32'(idx) < tmtw_pkg::CellCount) ? tmtw_pkg::IdxW'(idx) : '0;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    color_d      = color_q;
    top_d        = top_q;
    end_d        = end_q;
    rd_inrange_d = rd_inrange_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_cursor_d = out_cursor_q;
    out_char_d   = out_char_q;
    out_color_d  = out_color_q;
    emit         = 1'b0;
    row_n        = row_q;
    idle_wr      = '0;
    sw_cmd       = '0;
    sw_cmd.top   = top_lim;
    sw_cmd.fin   = end_lim;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (mode)
            tmtw_pkg::ModePrint: begin
              if (ch == tmtw_pkg::ChNewline) begin
                col_d = '0;
                row_n = row_q + tmtw_pkg::RowW'(1);
              end else if (ch != tmtw_pkg::ChNul) begin
                idle_wr.en   = 1'b1;
                idle_wr.addr = tmtw_pkg::IdxW'(cur_idx);
                idle_wr.data = {color_q, ch};
                if (col_q == LastCol) begin
                  col_d = '0;
                  row_n = row_q + tmtw_pkg::RowW'(1);
                end else begin
                  col_d = col_q + tmtw_pkg::ColW'(1);
                end
              end
              if (row_n == RowsEnd) begin
                row_d           = LastRow;
                sw_cmd.go       = 1'b1;
                sw_cmd.is_clear = 1'b0;
                state_d         = StSweep;
              end else begin
                row_d = row_n;
                emit  = 1'b1;
              end
            end
            tmtw_pkg::ModeBackspace: begin
              if (col_q != '0) begin
                col_d        = col_q - tmtw_pkg::ColW'(1);
                idle_wr.en   = 1'b1;
                idle_wr.addr = tmtw_pkg::IdxW'(cur_idx - tmtw_pkg::CntW'(1));
                idle_wr.data = blank;
              end
              emit = 1'b1;
            end
            tmtw_pkg::ModeClear: begin
              row_d           = top_lim;
              col_d           = '0;
              sw_cmd.go       = 1'b1;
              sw_cmd.is_clear = 1'b1;
              state_d         = StSweep;
            end
            tmtw_pkg::ModeRead: begin
              rd_inrange_d = (32'(idx) < tmtw_pkg::CellCount);
              state_d      = StRead;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      StRead: begin
        emit    = 1'b1;
        state_d = StIdle;
      end
      StSweep: begin
        if (sw_done) begin
          emit    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (emit) begin
      out_valid_d  = 1'b1;
      out_cursor_d = tmtw_pkg::CursorW'(tmtw_pkg::CntW'(row_d) * Cols +
                                        tmtw_pkg::CntW'(col_d));
      if (state_q == StRead && rd_inrange_q) begin
        out_char_d  = rd_data[7:0];
        out_color_d = rd_data[15:8];
      end else begin
        out_char_d  = '0;
        out_color_d = '0;
      end
    end

    if (cfg_valid_i) begin
      case (tmtw_pkg::cfg_reg_e'(cfg_index_i))
        tmtw_pkg::CfgTextColor: begin
          color_d = cfg_data_i;
        end
        tmtw_pkg::CfgTopRow: begin
          top_d = cfg_data_i[tmtw_pkg::RegRowW-1:0];
          row_d = cfg_top_lim;
          col_d = '0;
        end
        tmtw_pkg::CfgEndRow: begin
          end_d = cfg_data_i[tmtw_pkg::RegRowW-1:0];
          row_d = top_lim;
          col_d = '0;
        end
        default: begin
          color_d = color_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      row_q        <= '0;
      col_q        <= '0;
      color_q      <= '0;
      top_q        <= '0;
      end_q        <= tmtw_pkg::RegRowW'(tmtw_pkg::ROWS);
      rd_inrange_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_cursor_q <= '0;
      out_char_q   <= '0;
      out_color_q  <= '0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      color_q      <= color_d;
      top_q        <= top_d;
      end_q        <= end_d;
      rd_inrange_q <= rd_inrange_d;
      out_valid_q  <= out_valid_d;
      out_cursor_q <= out_cursor_d;
      out_char_q   <= out_char_d;
      out_color_q  <= out_color_d;
    end
  end

  // The engine owns both RAM ports while a scroll or clear runs.
  assign mem_wr  = sw_wr.en ? sw_wr : idle_wr;
  assign rd_addr = (state_q == StSweep) ? sw_rd_addr : idle_rd_addr;

  tmtw_sweep u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (sw_cmd),
    .blank_i   (blank),
    .rd_data_i (rd_data),
    .rd_addr_o (sw_rd_addr),
    .wr_o      (sw_wr),
    .done_o    (sw_done)
  );

  tmtw_ram #(
    .Width (tmtw_pkg::CellW),
    .Depth (tmtw_pkg::CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_wr.en),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_color_q, out_char_q, out_cursor_q};

endmodule

`default_nettype wire

// ----- rtl/tmtw_checker.sv -----
// Port-level checker for the text-mode terminal writer, bound to the top level.
// Depends on tmtw_pkg and text_mode_terminal_writer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "text_mode_terminal_writer_assert.svh"

module tmtw_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic [23:0]                       s_axis_tdata_i,
  input wire logic [tmtw_pkg::ModeW-1:0]        s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [31:0]                       m_axis_tdata_o,
  input wire logic                              cfg_valid_i,
  input wire logic                              cfg_ready_o,
  input wire logic [tmtw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input wire logic [tmtw_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic in_acc, is_clear, stalled, cfg_seen;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_clear = (s_axis_tuser_i == tmtw_pkg::ModeClear);
  assign stalled  = m_axis_tvalid_o && !m_axis_tready_i;
  // Config inputs are watched only so that the bind sees every port.
  assign cfg_seen = cfg_valid_i && cfg_ready_o && (cfg_index_i != '0 || cfg_data_i != '0);

  // A command either answers in the next cycle or holds off new commands.
  `TMTW_ASSERT_NEXT(a_accept_answers_or_busy, in_acc, m_axis_tvalid_o || !s_axis_tready_o)
  // A clear always walks the engine, so the block is busy right after it.
  `TMTW_ASSERT_NEXT(a_clear_is_busy, in_acc && is_clear, !s_axis_tready_o)
  // A pending result blocks new commands.
  `TMTW_ASSERT_NOW(a_stall_blocks_input, stalled, !s_axis_tready_o)
  // Reported cursor always lies on the screen.
  `TMTW_ASSERT_NOW(a_cursor_on_screen, m_axis_tvalid_o || cfg_seen,
                   !m_axis_tvalid_o || (32'(m_axis_tdata_o[10:0]) < tmtw_pkg::CellCount))
  `TMTW_ASSERT_NEXT(a_result_holds, stalled, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);

`default_nettype wire
